// ----- src/olpl_pkg.sv -----
// Shared types and constants of the object line parser/loader.
// No dependencies; the front, queue, emitter and top files import this package.
package olpl_pkg;

   localparam int LINE_COUNT_WIDTH_DEF = 16;
   localparam int BUF_BYTES            = 6;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_FORMAT  = 2'd2,
      KIND_OVERLAP = 2'd3
   } kind_type;

   // one finished line, as handed from the parser to the emitter
   typedef struct packed {
      kind_type        kind;
      logic [11:0]     addr;
      logic [2:0]      nwr;
      logic [5:0][7:0] bytes;
      logic [15:0]     line_num;
   } line_rec_type;

   // parser-side closing of a line, before the span check
   typedef struct packed {
      logic            bad;
      logic            blank;
      logic [11:0]     addr;
      logic [2:0]      nbytes;
      logic [5:0][7:0] bytes;
   } close_type;

   // queue handshake seen by the emitter
   typedef struct packed {
      logic empty;
      logic pop;
   } q_ctl_type;

endpackage

// ----- src/olpl_ifs.sv -----
// Channel interfaces of the object line parser/loader.
// No dependencies; olpl_pkg is not imported here.
interface olpl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_line;
   modport source (output valid, output text_char, output end_of_line, input ready);
   modport sink   (input valid, input text_char, input end_of_line, output ready);
endinterface

interface olpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [11:0] write_address;
   logic [7:0]  write_byte;
   logic [15:0] line_number;
   logic        last_of_line;
   modport source (output valid, output result_kind, output write_address,
                   output write_byte, output line_number, output last_of_line,
                   input ready);
   modport sink   (input valid, input result_kind, input write_address,
                   input write_byte, input line_number, input last_of_line,
                   output ready);
endinterface

// ----- src/olpl_front.sv -----
// Character parser and line checker: column state, then span/overlap check.
// Depends on olpl_pkg and olpl_req_if.
module olpl_front import olpl_pkg::*; #(
   parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   olpl_req_if.sink      req,
   input  logic          q_full,
   output logic          rec_push,
   output line_rec_type  rec
);

   logic [4:0]           col_ff, col_in;
   logic                 mal_ff, mal_in;
   logic                 blank_ff, blank_in;
   logic [11:0]          addr_ff, addr_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic                 ended_ff, ended_in;
   logic [5:0][7:0]      buf_ff, buf_in;

   close_type            close_ff, close_in;
   logic                 close_valid_ff;
   logic [12:0]          prev_end_ff;
   logic                 prev_valid_ff;
   logic [LINE_COUNT_WIDTH-1:0] count_ff, num;
   logic                 halted_ff;

   logic [7:0]  c;
   logic        ws, hv, take, close_go, overlap, accept;
   logic [3:0]  hval;
   logic [2:0]  bidx;
   logic [12:0] sum;
   logic [2:0]  nwr;
   logic [31:0] num_wide;

   assign c = req.text_char;
   assign ws = (c == 8'h20) || (c inside {[8'd9:8'd13]});

   always_comb begin
      hv   = 1'b1;
      hval = 4'h0;
      if (c inside {["0":"9"]}) begin
         hval = 4'(c - "0");
      end else if (c inside {["a":"f"]}) begin
         hval = 4'(c - "a" + 8'd10);
      end else if (c inside {["A":"F"]}) begin
         hval = 4'(c - "A" + 8'd10);
      end else begin
         hv = 1'b0;
      end
   end

   assign bidx = cnt_ff[3:1];

   always_comb begin
      mal_in   = mal_ff;
      blank_in = blank_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      ended_in = ended_ff;
      buf_in   = buf_ff;
      col_in   = (col_ff != 5'd31) ? col_ff + 5'd1 : col_ff;
      if (col_ff <= 5'd20 && !ws) blank_in = 1'b0;
      case (col_ff)
         5'd0, 5'd1, 5'd8, 5'd21: begin
            if (c != " ") mal_in = 1'b1;
         end
         5'd2: begin
            if (c != "0") mal_in = 1'b1;
         end
         5'd3: begin
            if (c != "x") mal_in = 1'b1;
         end
         5'd4, 5'd5, 5'd6: begin
            if (!hv) mal_in = 1'b1;
            else addr_in = {addr_ff[7:0], hval};
         end
         5'd7: begin
            if (c != ":") mal_in = 1'b1;
         end
         5'd22: begin
            if (c != "|") begin
               mal_in   = 1'b1;
               blank_in = 1'b0;
            end
         end
         default: begin
            if (col_ff inside {[5'd9:5'd20]}) begin
               if (ended_ff) begin
                  if (!ws) mal_in = 1'b1;
               end else if (hv && cnt_ff < 4'd12) begin
                  if (!cnt_ff[0]) buf_in[bidx] = {hval, 4'h0};
                  else buf_in[bidx] = buf_ff[bidx] | {4'h0, hval};
                  cnt_in = cnt_ff + 4'd1;
               end else if (ws) begin
                  if (c != " " && cnt_ff != 4'd0) mal_in = 1'b1;
                  ended_in = 1'b1;
               end else begin
                  mal_in = 1'b1;
               end
            end
         end
      endcase
   end

   assign close_in.bad    = (col_in < 5'd23) || (!blank_in && (mal_in || cnt_in[0]));
   assign close_in.blank  = blank_in;
   assign close_in.addr   = addr_in;
   assign close_in.nbytes = cnt_in[3:1];
   assign close_in.bytes  = buf_in;

   assign close_go  = close_valid_ff && (halted_ff || !q_full);
   assign req.ready = !close_valid_ff || close_go;
   assign take      = req.valid && req.ready;

   // line check against the previous span
   assign num      = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
   assign num_wide = 32'(num);
   assign sum      = {1'b0, close_ff.addr} + 13'(close_ff.nbytes);
   assign overlap  = !close_ff.blank && prev_valid_ff && (prev_end_ff > {1'b0, close_ff.addr});
   assign accept   = !close_ff.bad && !overlap;
   assign nwr      = close_ff.nbytes - (sum[12] ? sum[2:0] : 3'd0);

   always_comb begin
      rec.addr     = close_ff.addr;
      rec.bytes    = close_ff.bytes;
      rec.line_num = (num_wide > 32'hFFFF) ? 16'hFFFF : num_wide[15:0];
      rec.nwr      = 3'd0;
      if (close_ff.bad) begin
         rec.kind = KIND_FORMAT;
      end else if (overlap) begin
         rec.kind = KIND_OVERLAP;
      end else begin
         rec.kind = KIND_ACCEPT;
         if (!close_ff.blank) rec.nwr = nwr;
      end
   end

   assign rec_push = close_go && !halted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         mal_ff         <= 1'b0;
         blank_ff       <= 1'b1;
         addr_ff        <= '0;
         cnt_ff         <= '0;
         ended_ff       <= 1'b0;
         close_valid_ff <= 1'b0;
         prev_end_ff    <= '0;
         prev_valid_ff  <= 1'b0;
         count_ff       <= '0;
         halted_ff      <= 1'b0;
      end else begin
         if (take) begin
            if (req.end_of_line) begin
               col_ff   <= '0;
               mal_ff   <= 1'b0;
               blank_ff <= 1'b1;
               addr_ff  <= '0;
               cnt_ff   <= '0;
               ended_ff <= 1'b0;
            end else begin
               col_ff   <= col_in;
               mal_ff   <= mal_in;
               blank_ff <= blank_in;
               addr_ff  <= addr_in;
               cnt_ff   <= cnt_in;
               ended_ff <= ended_in;
            end
         end
         if (take && req.end_of_line) close_valid_ff <= 1'b1;
         else if (close_go) close_valid_ff <= 1'b0;
         if (rec_push) begin
            if (accept) begin
               count_ff <= num;
               if (!close_ff.blank && close_ff.nbytes != 3'd0) begin
                  prev_end_ff   <= sum;
                  prev_valid_ff <= 1'b1;
               end
            end else begin
               halted_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) buf_ff <= buf_in;
      if (take && req.end_of_line) close_ff <= close_in;
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_no_push_after_halt: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !rec_push)
      else $error("line record pushed after halt");

endmodule

// ----- src/olpl_queue.sv -----
// Two-entry line record queue between the parser and the emitter.
// Depends on olpl_pkg.
module olpl_queue import olpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  line_rec_type  push_rec,
   output logic          full,
   input  q_ctl_type     ctl_in,
   output logic          empty,
   output line_rec_type  head
);

   line_rec_type mem_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (ctl_in.pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(ctl_in.pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_rec;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2 && !(push && full) && !(ctl_in.pop && empty))
      else $error("queue overrun or underrun");

endmodule

// ----- src/olpl_back.sv -----
// Result emitter: byte writes of the head record, then its status beat.
// Depends on olpl_pkg and olpl_rsp_if.
module olpl_back import olpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  line_rec_type  head,
   output q_ctl_type     ctl,
   olpl_rsp_if.source    rsp
);

   logic        out_valid_ff;
   kind_type    kind_ff, kind_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] line_ff;
   logic        last_ff, last_in;
   logic [2:0]  idx_ff;
   logic        load, is_wr;

   assign load  = !out_valid_ff || rsp.ready;
   assign is_wr = idx_ff < head.nwr;

   always_comb begin
      if (is_wr) begin
         kind_in = KIND_WRITE;
         addr_in = head.addr + 12'(idx_ff);
         byte_in = head.bytes[idx_ff];
         last_in = 1'b0;
      end else begin
         kind_in = head.kind;
         addr_in = '0;
         byte_in = '0;
         last_in = 1'b1;
      end
   end

   assign ctl.empty = empty;
   assign ctl.pop   = load && !empty && !is_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (load) begin
         out_valid_ff <= !empty;
         if (!empty) idx_ff <= is_wr ? idx_ff + 3'd1 : 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         kind_ff <= kind_in;
         addr_ff <= addr_in;
         byte_ff <= byte_in;
         line_ff <= head.line_num;
         last_ff <= last_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.result_kind   = kind_ff;
   assign rsp.write_address = addr_ff;
   assign rsp.write_byte    = byte_ff;
   assign rsp.line_number   = line_ff;
   assign rsp.last_of_line  = last_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff <= head.nwr)
      else $error("write index ran past the line's byte count");

endmodule

// ----- src/object_line_parser_loader.sv -----
// Top level of the object line parser/loader: parser, line queue, emitter.
// Depends on olpl_pkg, olpl_ifs, olpl_front, olpl_queue, olpl_back.
//
//  channel  dir  beat
//  req_ch   in   text_char, end_of_line   (one character)
//  rsp_ch   out  result_kind, write_address, write_byte, line_number, last_of_line
//
// One character is taken per cycle unless req_ch stalls. A line is checked from its registered
// close record; its writes and status then leave at one beat per cycle from the output
// register while rsp_ch is ready, up to seven beats per line, behind a two-line queue.
// Reset is synchronous and clears all control state. req_ch stalls only when a
// finished line cannot enter a full queue; after an error input is drained.
module object_line_parser_loader import olpl_pkg::*; #(
   parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   olpl_req_if.sink    req_ch,
   olpl_rsp_if.source  rsp_ch
);

   logic         q_full, q_empty, rec_push;
   line_rec_type rec, head;
   q_ctl_type    q_ctl;

   olpl_front #(.LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_full   (q_full),
      .rec_push (rec_push),
      .rec      (rec)
   );

   olpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .full     (q_full),
      .ctl_in   (q_ctl),
      .empty    (q_empty),
      .head     (head)
   );

   olpl_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (q_empty),
      .head  (head),
      .ctl   (q_ctl),
      .rsp   (rsp_ch)
   );

endmodule
